>>> rtl/tts_pkg.sv
// Shared types and constants for the tunnel texture shader.
package tts_pkg;

	// Texture store geometry
	localparam int STORE_ADDR_W = 16;
	localparam int STORE_DEPTH  = 1 << STORE_ADDR_W;
	localparam int TEXEL_W      = 24;

	// Default texture size (log2 of texels per axis)
	localparam int TEX_WIDTH_LOG2_DEF  = 8;
	localparam int TEX_HEIGHT_LOG2_DEF = 8;

	// Fixed-point formats
	localparam int FRAC_W     = 16;  // 0.16 angle, phases, texture coordinates
	localparam int DEPTH_W    = 24;  // 8.16 depth
	localparam int FOG_FRAC_W = 19;  // fog has 19 fraction bits; with FOG_W it is a 1.19 value
	localparam int FOG_W      = FOG_FRAC_W + 1;
	localparam int COLOR_W    = 8;
	localparam int COORD_W    = 12;

	// Configuration reset values
	localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 12'd512;
	localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 12'd384;
	localparam logic [FRAC_W-1:0]  U_PHASE_RST      = 16'd0;
	localparam logic [FRAC_W-1:0]  V_PHASE_RST      = 16'd0;

	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_U_PHASE      = 2'd2,
		CFG_V_PHASE      = 2'd3
	} tts_cfg_idx_t;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_RENDER = 1'b1
	} tts_cmd_t;

	typedef struct packed {
		tts_cmd_t                command;
		logic [STORE_ADDR_W-1:0] texel_index;
		logic [TEXEL_W-1:0]      texel_rgb;
		logic [COORD_W-1:0]      column;
		logic [COORD_W-1:0]      row;
		logic [FRAC_W-1:0]       angle_frac;
		logic [DEPTH_W-1:0]      depth;
	} tts_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_column;
		logic [COORD_W-1:0] out_row;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} tts_out_t;

	// Texture store write and read request
	typedef struct packed {
		logic                    wr_en;
		logic [STORE_ADDR_W-1:0] wr_addr;
		logic [TEXEL_W-1:0]      wr_data;
		logic                    rd_en;
		logic [STORE_ADDR_W-1:0] rd_addr;
	} tts_ram_req_t;

endpackage

>>> rtl/tts_texture_ram.sv
// Texture store: one write port, one read port with registered read data.
module tts_texture_ram (
	input  logic                             clk,
	input  tts_pkg::tts_ram_req_t            req,
	output logic [tts_pkg::TEXEL_W-1:0]      rd_data
);

	logic [tts_pkg::TEXEL_W-1:0] mem [tts_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// read data holds while rd_en is low, so a stalled stage keeps its texel
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

>>> rtl/tunnel_texture_shader.sv
// Top level of the tunnel texture shader: three-stage pixel pipeline.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid / in_ready  | in_data  (tts_in_t: load or render)
//  out     | output    | out_valid / out_ready| out_data (tts_out_t: fogged pixel)
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data (register write)
//
// One transaction per clock in each direction when nothing stalls. A render
// transaction passes through the three pipeline registers before out_valid
// rises: coordinate/fog stage, texture store read stage and color multiply
// stage. Loads write the store in stage 2 and produce no output. Each stage
// has its own enable, so bubbles collapse and a stall at the output backs up
// stage by stage without losing or repeating a transaction.
// Reset clears the valid bits and the configuration registers; the texture
// store is not cleared and needs no sweep.
module tunnel_texture_shader #(
	parameter int TEX_WIDTH_LOG2  = tts_pkg::TEX_WIDTH_LOG2_DEF,
	parameter int TEX_HEIGHT_LOG2 = tts_pkg::TEX_HEIGHT_LOG2_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_ready,
	input  tts_pkg::tts_in_t                  in_data,

	output logic                              out_valid,
	input  logic                              out_ready,
	output tts_pkg::tts_out_t                 out_data,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  tts_pkg::tts_cfg_idx_t             cfg_index,
	input  logic [tts_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int TEX_COORD_W = TEX_WIDTH_LOG2 + TEX_HEIGHT_LOG2;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [tts_pkg::COORD_W-1:0] frame_width_q;
	logic [tts_pkg::COORD_W-1:0] frame_height_q;
	logic [tts_pkg::FRAC_W-1:0]  u_phase_q;
	logic [tts_pkg::FRAC_W-1:0]  v_phase_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= tts_pkg::FRAME_WIDTH_RST;
			frame_height_q <= tts_pkg::FRAME_HEIGHT_RST;
			u_phase_q      <= tts_pkg::U_PHASE_RST;
			v_phase_q      <= tts_pkg::V_PHASE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tts_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[tts_pkg::COORD_W-1:0];
				tts_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[tts_pkg::COORD_W-1:0];
				tts_pkg::CFG_U_PHASE:      u_phase_q      <= cfg_data[tts_pkg::FRAC_W-1:0];
				tts_pkg::CFG_V_PHASE:      v_phase_q      <= cfg_data[tts_pkg::FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage enables: a stage loads when it is empty or its successor moves
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3;
	logic en1, en2, en3;

	assign en3      = !valid_s3 || out_ready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	// ------------------------------------------------------------------
	// Stage 1: texture address, fog factor, center test
	// ------------------------------------------------------------------
	logic [tts_pkg::FRAC_W-1:0]       tex_u, tex_v;
	logic [TEX_WIDTH_LOG2-1:0]        tex_x;
	logic [TEX_HEIGHT_LOG2-1:0]       tex_y;
	logic [TEX_COORD_W-1:0]           tex_coord;
	logic [tts_pkg::FOG_W-1:0]        fog_c;
	logic                             centre_c;

	// u = frac(angle*8 - u_phase), v = frac(depth + v_phase)
	assign tex_u = {in_data.angle_frac[tts_pkg::FRAC_W-4:0], 3'b000} - u_phase_q;
	assign tex_v = in_data.depth[tts_pkg::FRAC_W-1:0] + v_phase_q;
	assign tex_x = tex_u[tts_pkg::FRAC_W-1 -: TEX_WIDTH_LOG2];
	assign tex_y = tex_v[tts_pkg::FRAC_W-1 -: TEX_HEIGHT_LOG2];
	assign tex_coord = {tex_y, tex_x};

	// fog = 1 - depth/8 in 1.19, clamped at zero
	always_comb begin
		if (in_data.depth >= tts_pkg::DEPTH_W'(1 << tts_pkg::FOG_FRAC_W)) begin
			fog_c = '0;
		end else begin
			fog_c = tts_pkg::FOG_W'(1 << tts_pkg::FOG_FRAC_W)
				- in_data.depth[tts_pkg::FOG_W-1:0];
		end
	end

	assign centre_c = (in_data.row    == {1'b0, frame_height_q[tts_pkg::COORD_W-1:1]})
	               && (in_data.column == {1'b0, frame_width_q[tts_pkg::COORD_W-1:1]});

	tts_pkg::tts_cmd_t                 command_s1;
	logic [tts_pkg::STORE_ADDR_W-1:0]  texel_index_s1;
	logic [tts_pkg::TEXEL_W-1:0]       texel_rgb_s1;
	logic [tts_pkg::COORD_W-1:0]       column_s1, row_s1;
	logic [tts_pkg::STORE_ADDR_W-1:0]  rd_addr_s1;
	logic [tts_pkg::FOG_W-1:0]         fog_s1;
	logic                              centre_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			command_s1     <= in_data.command;
			texel_index_s1 <= in_data.texel_index;
			texel_rgb_s1   <= in_data.texel_rgb;
			column_s1      <= in_data.column;
			row_s1         <= in_data.row;
			rd_addr_s1     <= tts_pkg::STORE_ADDR_W'(tex_coord);  // wraps over the store
			fog_s1         <= fog_c;
			centre_s1      <= centre_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: texture store write (load) or read (render), in order
	// ------------------------------------------------------------------
	tts_pkg::tts_ram_req_t            ram_req;
	logic [tts_pkg::TEXEL_W-1:0]      texel_s2;

	assign ram_req.wr_en   = en2 && valid_s1 && (command_s1 == tts_pkg::CMD_LOAD);
	assign ram_req.wr_addr = texel_index_s1;
	assign ram_req.wr_data = texel_rgb_s1;
	assign ram_req.rd_en   = en2 && valid_s1 && (command_s1 == tts_pkg::CMD_RENDER);
	assign ram_req.rd_addr = rd_addr_s1;

	tts_texture_ram u_texture_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (texel_s2)
	);

	logic [tts_pkg::COORD_W-1:0]      column_s2, row_s2;
	logic [tts_pkg::FOG_W-1:0]        fog_s2;
	logic                             centre_s2;

	// loads leave the pipe here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1 && (command_s1 == tts_pkg::CMD_RENDER);
		end
	end

	always_ff @(posedge clk) begin
		if (ram_req.rd_en) begin
			column_s2 <= column_s1;
			row_s2    <= row_s1;
			fog_s2    <= fog_s1;
			centre_s2 <= centre_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: color * fog, truncated; center pixel forced black
	// ------------------------------------------------------------------
	localparam int PROD_W = tts_pkg::COLOR_W + tts_pkg::FOG_W;

	logic [PROD_W-1:0]                prod_r, prod_g, prod_b;
	tts_pkg::tts_out_t                out_c;

	assign prod_r = PROD_W'(texel_s2[23:16]) * PROD_W'(fog_s2);
	assign prod_g = PROD_W'(texel_s2[15:8])  * PROD_W'(fog_s2);
	assign prod_b = PROD_W'(texel_s2[7:0])   * PROD_W'(fog_s2);

	always_comb begin
		out_c.out_column = column_s2;
		out_c.out_row    = row_s2;
		if (centre_s2) begin
			out_c.red   = '0;
			out_c.green = '0;
			out_c.blue  = '0;
		end else begin
			out_c.red   = prod_r[tts_pkg::FOG_FRAC_W +: tts_pkg::COLOR_W];
			out_c.green = prod_g[tts_pkg::FOG_FRAC_W +: tts_pkg::COLOR_W];
			out_c.blue  = prod_b[tts_pkg::FOG_FRAC_W +: tts_pkg::COLOR_W];
		end
	end

	tts_pkg::tts_out_t                out_data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			out_data_s3 <= out_c;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = out_data_s3;

endmodule
